/* sv/cfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame encoder package
// Shared constants, the sequencer state type and the byte beat that runs
// from the sequencer to the output packer.
// ----------------------------------------------------------------------------
package cfe_pkg;

    // Largest number of data bytes in one group, and the group store depth.
    localparam int GROUP_MAX = 254;

    // Address width of the group store.
    localparam int ADDR_W = 8;

    // Code byte values.
    localparam logic [7:0] CODE_EMPTY = 8'd1;
    localparam logic [7:0] CODE_FULL  = 8'd255;
    localparam logic [7:0] CODE_LIMIT = 8'd254;

    // Frame delimiter.
    localparam logic [7:0] FRAME_DELIM = 8'h00;

    // Width of the packed output word and of its byte count.
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CODE,
        ST_DATA,
        ST_TAIL,
        ST_DELIM
    } t_state;

    // One encoded byte on its way to the packer.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       frame_done;
    } t_beat;

endpackage

/* sv/cfe_group_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS group store
// Single-port-write, single-port-read memory holding the data bytes of the
// open group. Read data is registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module cfe_group_ram
    import cfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [GROUP_MAX];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cfe_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS output packer
// Collects encoded bytes low lane first into words of up to OUT_LANES bytes and
// hands each finished word to a one-entry output register.
// ----------------------------------------------------------------------------
module cfe_packer
    import cfe_pkg::*;
#(
    parameter int OUT_LANES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat_valid,
    input  t_beat              i_beat,
    output logic               o_beat_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WORD_W-1:0]  o_out_word,
    output logic [COUNT_W-1:0] o_byte_count,
    output logic               o_run_last,
    output logic               o_frame_done
);

    localparam int CNT_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

    logic [CNT_W-1:0]   r_acc_cnt;
    logic [CNT_W-1:0]   n_acc_cnt;
    logic [WORD_W-1:0]  r_acc_word;
    logic [WORD_W-1:0]  n_acc_word;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_run_last;
    logic               r_out_frame_done;

    logic               completes;
    logic               beat_fire;

    // A beat finishes the word when it fills the last lane or ends the run.
    assign completes    = i_beat.run_last || (r_acc_cnt == CNT_W'(OUT_LANES - 1));
    assign o_beat_ready = !completes || !r_out_valid || i_ready;
    assign beat_fire    = i_beat_valid && o_beat_ready;

    // Merge the new byte into its lane; lanes above it read as zero.
    always_comb begin
        n_acc_word = '0;
        for (int j = 0; j < OUT_LANES; j++) begin
            if (CNT_W'(j) < r_acc_cnt) begin
                n_acc_word[8*j +: 8] = r_acc_word[8*j +: 8];
            end else if (CNT_W'(j) == r_acc_cnt) begin
                n_acc_word[8*j +: 8] = i_beat.data;
            end
        end
    end

    assign n_acc_cnt = completes ? '0 : r_acc_cnt + CNT_W'(1);

    // Lane counter and output handshake state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (beat_fire) begin
                r_acc_cnt <= n_acc_cnt;
            end
            if (beat_fire && completes) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Accumulator and output payload.
    always_ff @(posedge i_clk) begin
        if (beat_fire) begin
            r_acc_word <= n_acc_word;
            if (completes) begin
                r_out_word       <= n_acc_word;
                r_out_cnt        <= COUNT_W'(r_acc_cnt) + COUNT_W'(1);
                r_out_run_last   <= i_beat.run_last;
                r_out_frame_done <= i_beat.frame_done;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_word   = r_out_word;
    assign o_byte_count = r_out_cnt;
    assign o_run_last   = r_out_run_last;
    assign o_frame_done = r_out_frame_done;

endmodule

/* sv/cobs_frame_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame encoder
// Consistent overhead byte stuffing of a frame presented one byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one raw byte with i_frame_last
//   set on the frame's final byte. Output channel (o_valid / i_ready) gives
//   the encoded stream packed low byte first, up to OUT_LANES bytes per transfer;
//   o_run_last marks the last transfer caused by an input byte and
//   o_frame_done the transfer that ends with the 0x00 delimiter.
// Timing:
//   A non-zero byte that neither ends the frame nor fills a group produces
//   nothing. A byte that flushes a group holds off the input while the
//   sequencer emits its bytes (code, data, an extra empty code where needed,
//   delimiter): the group store has one read port and the sequencer drains
//   it one byte per cycle while the packer accepts bytes. The final word is
//   visible in the cycle after its last byte is emitted.
// Reset:
//   The group code returns to one and the output register empties. The
//   group store is not cleared; only entries written in the current group
//   are read.
// Stalls:
//   One finished word waits in the output register; the sequencer stops
//   when the next word completes and resumes as soon as the word is taken.
// ----------------------------------------------------------------------------
module cobs_frame_encoder
    import cfe_pkg::*;
#(
    parameter int OUT_LANES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WORD_W-1:0]  o_out_word,
    output logic [COUNT_W-1:0] o_byte_count,
    output logic               o_run_last,
    output logic               o_frame_done
);

    t_state            r_state;
    t_state            n_state;
    t_state            after_flush;
    logic [7:0]        r_code;
    logic [7:0]        r_flush_code;
    logic [ADDR_W-1:0] r_idx;
    logic              r_last;
    logic              r_tail;

    logic              in_fire;
    logic              in_zero;
    logic              grp_full;
    logic              need_flush;
    logic [7:0]        code_inc;
    logic [7:0]        flush_code;
    logic [7:0]        data_cnt;
    logic              data_done;

    logic              beat_valid;
    logic              beat_ready;
    logic              beat_fire;
    t_beat             beat;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Input decode.
    assign in_fire    = i_valid && o_ready;
    assign o_ready    = (r_state == ST_IDLE);
    assign in_zero    = (i_data_byte == 8'd0);
    assign code_inc   = r_code + 8'd1;
    assign grp_full   = !in_zero && (r_code == CODE_LIMIT);
    assign need_flush = in_zero || grp_full || i_frame_last;

    // Code byte of the group that this input flushes.
    always_comb begin
        priority if (in_zero) begin
            flush_code = r_code;
        end else if (grp_full) begin
            flush_code = CODE_FULL;
        end else begin
            flush_code = code_inc;
        end
    end

    // Progress through the flushed group's data bytes.
    assign data_cnt  = r_flush_code - 8'd1;
    assign data_done = (r_idx == data_cnt);
    assign beat_fire = beat_valid && beat_ready;

    // Where the sequencer goes once the group's bytes are out.
    always_comb begin
        priority if (r_tail) begin
            after_flush = ST_TAIL;
        end else if (r_last) begin
            after_flush = ST_DELIM;
        end else begin
            after_flush = ST_IDLE;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && need_flush) begin
                    n_state = ST_CODE;
                end
            end
            ST_CODE: begin
                if (beat_fire) begin
                    n_state = (data_cnt != 8'd0) ? ST_DATA : after_flush;
                end
            end
            ST_DATA: begin
                if (beat_fire && data_done) begin
                    n_state = after_flush;
                end
            end
            ST_TAIL: begin
                if (beat_fire) begin
                    n_state = ST_DELIM;
                end
            end
            ST_DELIM: begin
                if (beat_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: the byte offered to the packer and the store read.
    always_comb begin
        beat_valid      = 1'b0;
        beat.data       = FRAME_DELIM;
        beat.run_last   = 1'b0;
        beat.frame_done = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                beat_valid = 1'b0;
            end
            ST_CODE: begin
                beat_valid    = 1'b1;
                beat.data     = r_flush_code;
                beat.run_last = (data_cnt == 8'd0) && !r_last;
                ram_re        = beat_fire && (data_cnt != 8'd0);
                ram_raddr     = '0;
            end
            ST_DATA: begin
                beat_valid    = 1'b1;
                beat.data     = ram_rdata;
                beat.run_last = data_done && !r_last;
                ram_re        = beat_fire && !data_done;
            end
            ST_TAIL: begin
                beat_valid = 1'b1;
                beat.data  = CODE_EMPTY;
            end
            ST_DELIM: begin
                beat_valid      = 1'b1;
                beat.data       = FRAME_DELIM;
                beat.run_last   = 1'b1;
                beat.frame_done = 1'b1;
            end
            default: begin
                beat_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_code  <= CODE_EMPTY;
            r_last  <= 1'b0;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_code <= need_flush ? CODE_EMPTY : code_inc;
                r_last <= i_frame_last;
                r_tail <= i_frame_last && (in_zero || grp_full);
            end
        end
    end

    // Flush code and read pointer.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_flush_code <= flush_code;
        end
        if (ram_re) begin
            r_idx <= ram_raddr + ADDR_W'(1);
        end
    end

    // Group store: non-zero bytes are written at their place in the group.
    cfe_group_ram u_group_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && !in_zero),
        .i_waddr (r_code - 8'd1),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Byte-to-word packing and output register.
    cfe_packer #(
        .OUT_LANES (OUT_LANES)
    ) u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .o_beat_ready (beat_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_word   (o_out_word),
        .o_byte_count (o_byte_count),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

endmodule

/* sim/tb_cobs_frame_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame encoder testbench
// Drives frames of raw bytes into the encoder and checks every packed output
// word against a byte-level encoding model kept in a small scoreboard. A
// short directed set covers single-byte frames, zero bytes, quiet bytes and
// a two-word burst. Random frames follow under three idling patterns, with
// one frame whose last byte fills a group and causes the longest burst.
// ----------------------------------------------------------------------------
module tb_cobs_frame_encoder;
    import cfe_pkg::*;

    localparam int LANES = 8;

    // One expected or observed output transfer.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
        logic               run_last;
        logic               frame_done;
    } t_enc_word;

    // Encoding model and queue of expected output words.
    class cobs_word_checker;
        logic [7:0] group_bytes [GROUP_MAX];
        int         group_code;
        logic [7:0] burst [$];
        t_enc_word  expected_words [$];
        int         errors;

        function new();
            group_code = CODE_EMPTY;
            errors     = 0;
        endfunction

        task report(input string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        // Release the code byte and the buffered data bytes of one group.
        function void release_group(input int code);
            burst.push_back(code[7:0]);
            for (int i = 0; i + 1 < code; i++) begin
                burst.push_back(group_bytes[i]);
            end
        endfunction

        // Note one accepted byte and queue the words it should produce.
        function void note_byte(input logic [7:0] b, input logic last);
            int        code;
            int        cnt;
            t_enc_word w;

            code = group_code;
            burst.delete();
            if (b == 8'h00) begin
                release_group(code);
                code = CODE_EMPTY;
            end else begin
                group_bytes[code - 1] = b;
                code++;
                if (code == CODE_FULL) begin
                    release_group(code);
                    code = CODE_EMPTY;
                end
            end
            if (last) begin
                release_group(code);
                code = CODE_EMPTY;
                burst.push_back(FRAME_DELIM);
            end
            group_code = code;

            // Pack the released bytes low byte first.
            for (int k = 0; k < burst.size(); k += LANES) begin
                cnt = burst.size() - k;
                if (cnt > LANES) begin
                    cnt = LANES;
                end
                w.word = '0;
                for (int j = 0; j < cnt; j++) begin
                    w.word[8*j +: 8] = burst[k + j];
                end
                w.count      = cnt[COUNT_W-1:0];
                w.run_last   = (k + cnt == burst.size());
                w.frame_done = w.run_last && last;
                expected_words.push_back(w);
            end
        endfunction

        // Compare one output transfer with the oldest expected word.
        task check_word(input t_enc_word got);
            t_enc_word exp_w;

            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h count %0d", got.word, got.count));
            end else begin
                exp_w = expected_words.pop_front();
                if (got.word !== exp_w.word)
                    report($sformatf("word %h, expected %h", got.word, exp_w.word));
                if (got.count !== exp_w.count)
                    report($sformatf("byte count %0d, expected %0d", got.count,
                                     exp_w.count));
                if (got.run_last !== exp_w.run_last)
                    report($sformatf("run_last %b, expected %b", got.run_last,
                                     exp_w.run_last));
                if (got.frame_done !== exp_w.frame_done)
                    report($sformatf("frame_done %b, expected %b", got.frame_done,
                                     exp_w.frame_done));
            end
        endtask
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [7:0]         i_data_byte  = 8'h00;
    logic               i_frame_last = 1'b0;
    logic               i_ready      = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [WORD_W-1:0]  o_out_word;
    logic [COUNT_W-1:0] o_byte_count;
    logic               o_run_last;
    logic               o_frame_done;

    int send_idle = 33;
    int recv_idle = 83;

    cobs_word_checker checker_h = new();

    cobs_frame_encoder #(
        .OUT_LANES(LANES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_frame_last(i_frame_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_word  (o_out_word),
        .o_byte_count(o_byte_count),
        .o_run_last  (o_run_last),
        .o_frame_done(o_frame_done)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver stalls at random on the falling edge.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Check each output transfer at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            checker_h.check_word({o_out_word, o_byte_count, o_run_last, o_frame_done});
        end
    end

    // Offer one byte, with random idle cycles ahead of it, until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_frame_last <= last;
        do @(posedge i_clk); while (!o_ready);
        checker_h.note_byte(b, last);
        @(negedge i_clk);
    endtask

    // Send one frame of random bytes; zero_pct sets the share of zero bytes.
    task automatic random_frame(input int len, input int zero_pct);
        logic [7:0] b;

        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < zero_pct) begin
                b = 8'h00;
            end else begin
                case ($urandom_range(3))
                    0:       b = 8'hFF;
                    1:       b = 8'h01;
                    default: b = 8'($urandom_range(255, 1));
                endcase
            end
            send_byte(b, i == len - 1);
        end
    endtask

    // One idling pattern: an optional long all-non-zero frame, then short frames.
    task automatic run_phase(input int s_idle, input int r_idle, input int long_len,
                             input int budget);
        int sent;
        int len;
        int zero_pct;

        send_idle = s_idle;
        recv_idle = r_idle;
        if (long_len > 0) begin
            random_frame(long_len, 0);
        end
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            case ($urandom_range(4))
                0:       zero_pct = 0;
                1:       zero_pct = 10;
                2:       zero_pct = 30;
                3:       zero_pct = 60;
                default: zero_pct = 100;
            endcase
            random_frame(len, zero_pct);
            sent += len;
        end
    endtask

    // Main sequence.
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single-byte frames at the field extremes.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Quiet bytes, then a zero, then the frame end.
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // Zero bytes back to back.
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b1);
        // Frame that ends on a zero byte.
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b1);
        // Nine data bytes: the burst spans two output words.
        for (int i = 1; i <= 9; i++) begin
            send_byte(8'(i * 28), i == 9);
        end

        // Random frames; the second pattern opens with the longest single burst.
        run_phase(33, 83, 0, 60);
        run_phase(83, 33, GROUP_MAX, 60);
        run_phase(0, 0, 0, 60);
        i_valid <= 1'b0;

        // Drain, then allow a margin for any stray output.
        while (checker_h.expected_words.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (checker_h.expected_words.size() > 0) begin
            checker_h.report("expected words left over");
        end
        if (checker_h.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
